// ----- rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- rtl/sorted_set_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_set_table_top
// Sorted set of distinct signed 32-bit values with insert/remove/query/clear.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_mode and i_value with start high; the transfer
//   happens at a rising edge where start is high and busy is low.
//   Result channel: o_valid is high for exactly one cycle with o_done_res,
//   o_position and o_count; the receiver must take it then, it cannot stall.
//   The result strobe follows the command transfer through ST_CALC, then ST_REPLY.
//   No command transfers while busy (ST_CALC); a new command may transfer in
//   the cycle its predecessor's result is shown.
//   Per command, every table entry compares against the value in parallel
//   and shifts up or down in the same execute cycle.
//   Reset (i_rst_n low, synchronous) empties the set and idles the sequencer;
//   table contents are don't-care until written.
// ----------------------------------------------------------------------------
module sorted_set_table_top import sst_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_valid,
    output logic                    o_done_res,
    output logic [POS_W-1:0]        o_position,
    output logic [COUNT_W-1:0]      o_count
);

    t_dp_cmd cmd;

    sst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    sst_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_done_res (o_done_res),
        .o_position (o_position),
        .o_count    (o_count)
    );

endmodule

// ----- rtl/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: latches a command, runs one table update, presents the result.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_REPLY = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy    = (r_state == ST_CALC);
    assign o_valid = (r_state == ST_REPLY);
    assign accept  = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                n_state = accept ? ST_CALC : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == ST_CALC);

endmodule

// ----- rtl/sst_dp.sv -----
// ----------------------------------------------------------------------------
// sst_dp
// Table datapath: per-entry compare cells and shift-up/shift-down update.
// ----------------------------------------------------------------------------
module sst_dp import sst_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                 o_done_res,
    output logic [POS_W-1:0]     o_position,
    output logic [COUNT_W-1:0]   o_count
);

    t_mode                   r_mode;
    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] r_entries [CAPACITY];
    logic signed [VAL_W-1:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_done_res;
    logic                    n_done_res;
    logic [IDX_W-1:0]        r_position;
    logic [IDX_W-1:0]        n_position;

    logic [CAPACITY-1:0]     valid;
    logic [CAPACITY-1:0]     lt;
    logic [CAPACITY-1:0]     eq;
    logic [CAPACITY-1:0]     lt_prev;
    logic                    found;
    logic                    full;
    logic [IDX_W-1:0]        found_idx;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = (CNT_W'(i) < r_count);
            lt[i]    = valid[i] && (r_entries[i] < r_value);
            eq[i]    = valid[i] && (r_entries[i] == r_value);
        end
    end

    always_comb begin
        lt_prev[0] = 1'b1;
        for (int i = 1; i < CAPACITY; i++) begin
            lt_prev[i] = lt[i-1];
        end
    end

    always_comb begin
        found_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (eq[i]) found_idx = found_idx | IDX_W'(i);
        end
    end

    assign found = |eq;
    assign full  = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_count    = r_count;
        n_done_res = 1'b0;
        n_position = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_entries[i] = r_entries[i];
        end
        unique case (r_mode)
            MODE_INSERT: begin
                if (!full && !found) begin
                    n_count    = r_count + CNT_W'(1);
                    n_done_res = 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!lt[i]) begin
                            if (lt_prev[i]) n_entries[i] = r_value;
                            else            n_entries[i] = r_entries[(i > 0) ? i - 1 : 0];
                        end
                    end
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    n_count    = r_count - CNT_W'(1);
                    n_done_res = 1'b1;
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!lt[i]) n_entries[i] = r_entries[i+1];
                    end
                end
            end
            MODE_QUERY: begin
                if (found) begin
                    n_done_res = 1'b1;
                    n_position = found_idx;
                end
            end
            MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_done_res <= n_done_res;
            r_position <= n_position;
            for (int i = 0; i < CAPACITY; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_done_res = r_done_res;
    assign o_position = POS_W'(r_position);
    assign o_count    = COUNT_W'(r_count);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("stored count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_mode == MODE_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_mode == MODE_INSERT && full) |=> (!r_done_res && $stable(r_count)))
        else $error("insert accepted on full table");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> $onehot0(eq))
        else $error("duplicate values in table");

endmodule
